// ----- design/sha1_pkg.sv -----
// ---------------------------------------------------------------------------
// sha1_pkg
// Shared commands, constants and round functions of the SHA-1 digest block.
// ---------------------------------------------------------------------------
package sha1_pkg;

    typedef enum logic [1:0] {
        CMD_ABSORB  = 2'd0,
        CMD_FINISH  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = H0;
            3'd1:    v = H1;
            3'd2:    v = H2;
            3'd3:    v = H3;
            default: v = H4;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_fk(input logic [6:0] rnd,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] v;
        if (rnd < 7'd20)
            v = ((b & c) | (~b & d)) + 32'h5A827999;
        else if (rnd < 7'd40)
            v = (b ^ c ^ d) + 32'h6ED9EBA1;
        else if (rnd < 7'd60)
            v = ((b & c) | (b & d) | (c & d)) + 32'h8F1BBCDC;
        else
            v = (b ^ c ^ d) + 32'hCA62C1D6;
        return v;
    endfunction

endpackage

// ----- design/sha1_ram.sv -----
// ---------------------------------------------------------------------------
// sha1_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module sha1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sha1_message_digest.sv -----
// ---------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream with padding and five-word digest output.
// ---------------------------------------------------------------------------
// Bytes are absorbed one per cycle while the block is idle. The byte that
// fills a 64-byte block starts a compression: the schedule is loaded from
// the block memory one byte per read (the read is registered), then a wait
// state, 80 rounds at one per cycle, and a fold into the chaining words. A
// finish runs one or two padded compressions (the tail is read from the
// block memory byte by byte), then delivers five words, one per cycle as
// the result side takes them. A finish after a finish only re-emits. Input
// ready is low during compression and while digest words are pending.
// ---------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] chain_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic        done_reg;
    logic        fin_reg;      // compression belongs to a finish
    logic        second_reg;   // second padded block pending
    logic        padblk_reg;   // current block is the pure length block
    logic [6:0]  cnt_reg;      // load byte / round counter
    logic [5:0]  tail_reg;     // fill count latched at finish
    logic [31:0] wacc_reg;
    logic [2:0]  widx_reg;

    logic        acc;
    logic        bw_we;
    logic [5:0]  bw_addr, br_addr;
    logic [7:0]  bw_data, br_data;
    logic        ww_we;
    logic [3:0]  ww_addr, wr_addr;
    logic [31:0] ww_data, wr_data;

    assign acc     = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_digest_word = chain_reg[widx_reg];
    assign m_word_index  = widx_reg;
    assign m_last_word   = (widx_reg == 3'd4);

    sha1_ram #(.WIDTH(8), .DEPTH(64)) u_blk (
        .aclk(aclk), .we(bw_we), .waddr(bw_addr), .wdata(bw_data),
        .raddr(br_addr), .rdata(br_data)
    );

    sha1_ram #(.WIDTH(32), .DEPTH(16)) u_sched (
        .aclk(aclk), .we(ww_we), .waddr(ww_addr), .wdata(ww_data),
        .raddr(wr_addr), .rdata(wr_data)
    );

    assign bw_we   = acc && (s_cmd == sha1_pkg::CMD_ABSORB) && !done_reg;
    assign bw_addr = fill_reg;
    assign bw_data = s_data_byte;

    // Byte of the padded message at a block position during load.
    logic [7:0] pad_byte;
    logic [5:0] pos;
    logic       pos_valid;
    assign pos       = cnt_reg[5:0] - 6'd1;
    assign pos_valid = (cnt_reg != 7'd0) && (cnt_reg <= 7'd64);
    always_comb begin
        if (!fin_reg)
            pad_byte = br_data;
        else if (pos >= 6'(sha1_pkg::LEN_POS) && (padblk_reg || tail_reg < 6'd56))
            pad_byte = bits_reg[8'(7 - (pos - 6'(sha1_pkg::LEN_POS))) * 8 +: 8];
        else if (!padblk_reg && pos < tail_reg)
            pad_byte = br_data;
        else if (!padblk_reg && pos == tail_reg)
            pad_byte = sha1_pkg::PAD_BYTE;
        else
            pad_byte = 8'h00;
    end

    // Schedule memory: slot i holds the raw block word w[i] for the first
    // 16 rounds. The expansion needs four words a round; the schedule memory
    // reads one per cycle, so a 16-word shift line of taps carries the
    // window from round 16 on.
    logic [31:0] win [16];
    logic [31:0] wnew, wi, t;
    logic [6:0]  rnd;
    assign rnd  = cnt_reg;
    assign wnew = {win[13] ^ win[8] ^ win[2] ^ win[0]} << 1 |
                  {win[13] ^ win[8] ^ win[2] ^ win[0]} >> 31;
    assign wi   = (rnd < 7'd16) ? wr_data : wnew;
    assign t    = {a_reg[26:0], a_reg[31:27]} + e_reg + wi +
                  sha1_pkg::round_fk(rnd, b_reg, c_reg, d_reg);

    assign ww_we   = (state_reg == ST_LOAD) && pos_valid && (pos[1:0] == 2'd3);
    assign ww_addr = pos[5:2];
    assign ww_data = {wacc_reg[23:0], pad_byte};
    assign br_addr = (state_reg == ST_LOAD) ? cnt_reg[5:0] : 6'd0;
    assign wr_addr = (state_reg == ST_ROUND) ? 4'(rnd + 7'd1) : 4'd0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_cmd == sha1_pkg::CMD_ABSORB && !done_reg && fill_reg == 6'd63)
                        state_next = ST_LOAD;
                    else if (s_cmd == sha1_pkg::CMD_FINISH)
                        state_next = done_reg ? ST_EMIT : ST_LOAD;
                end
            end
            ST_LOAD:  if (cnt_reg == 7'd64) state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_ROUND;
            ST_ROUND: if (rnd == 7'd79) state_next = ST_FOLD;
            ST_FOLD: begin
                if (second_reg)     state_next = ST_LOAD;
                else if (fin_reg)   state_next = ST_EMIT;
                else                state_next = ST_IDLE;
            end
            ST_EMIT: if (m_ready && widx_reg == 3'd4) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            done_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            second_reg <= 1'b0;
            padblk_reg <= 1'b0;
            cnt_reg   <= '0;
            widx_reg  <= '0;
            for (int i = 0; i < 5; i++)
                chain_reg[i] <= sha1_pkg::init_word(3'(i));
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg  <= '0;
                    widx_reg <= '0;
                    if (acc) begin
                        case (s_cmd)
                            sha1_pkg::CMD_ABSORB: if (!done_reg) begin
                                fill_reg <= fill_reg + 6'd1;
                                bits_reg <= bits_reg + 64'd8;
                                fin_reg  <= 1'b0;
                                padblk_reg <= 1'b0;
                            end
                            sha1_pkg::CMD_FINISH: if (!done_reg) begin
                                fin_reg    <= 1'b1;
                                padblk_reg <= 1'b0;
                                tail_reg   <= fill_reg;
                                second_reg <= (fill_reg >= 6'd56);
                                done_reg   <= 1'b1;
                            end
                            sha1_pkg::CMD_RESTART: begin
                                fill_reg <= '0;
                                bits_reg <= '0;
                                done_reg <= 1'b0;
                                for (int i = 0; i < 5; i++)
                                    chain_reg[i] <= sha1_pkg::init_word(3'(i));
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOAD: begin
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (pos_valid) begin
                        wacc_reg <= {wacc_reg[23:0], pad_byte};
                        if (pos[1:0] == 2'd3)
                            win[pos[5:2]] <= {wacc_reg[23:0], pad_byte};
                    end
                    a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
                    c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
                    e_reg <= chain_reg[4];
                end
                ST_WAIT: cnt_reg <= '0;
                ST_ROUND: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    // advance the window once the expanded words start
                    if (rnd >= 7'd16) begin
                        for (int i = 0; i < 15; i++)
                            win[i] <= win[i+1];
                        win[15] <= wnew;
                    end
                    a_reg <= t; b_reg <= a_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    d_reg <= c_reg; e_reg <= d_reg;
                end
                ST_FOLD: begin
                    cnt_reg <= '0;
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    if (second_reg) begin
                        second_reg <= 1'b0;
                        padblk_reg <= 1'b1;
                    end
                    if (!fin_reg) fill_reg <= '0;
                end
                ST_EMIT: if (m_ready) widx_reg <= widx_reg + 3'd1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> widx_reg <= 3'd4) else $error("word index out of range");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> !s_ready) else $error("accept during rounds");
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> done_reg) else $error("digest without finish");
    a_fold_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> $past(state_reg == ST_ROUND && rnd == 7'd79))
        else $error("fold without full rounds");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives byte streams, finishes and restarts into the SHA-1 digest block and
// checks every digest word against a behavioral hash kept in the bench.
// ---------------------------------------------------------------------------
module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    sha1_message_digest u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    typedef struct {
        sha1_pkg::cmd_t cmd;
        logic [7:0]     data;
        logic           has_word;
        logic [31:0]    word_a;
    } request_row_t;

    // hash state held by the bench
    logic [31:0]  chain [5];
    logic [7:0]   block_bytes [64];
    int unsigned  fill;
    logic [63:0]  msg_bits;
    logic         finished;
    digest_word_t digest_q [$];

    int unsigned  err_count;
    int unsigned  cycle_count;
    request_row_t dir_rows [$];

    localparam int unsigned CYCLE_LIMIT = 1500000;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress(input logic [7:0] blk [64]);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic hash_restart();
        chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
        chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
        fill = 0;
        msg_bits = '0;
        finished = 1'b0;
    endtask

    task automatic hash_apply(input sha1_pkg::cmd_t cmd, input logic [7:0] data);
        logic [7:0] pad [64];
        case (cmd)
            sha1_pkg::CMD_ABSORB: begin
                if (!finished) begin
                    block_bytes[fill] = data;
                    msg_bits += 64'd8;
                    fill++;
                    if (fill == 64) begin
                        compress(block_bytes);
                        fill = 0;
                    end
                end
            end
            sha1_pkg::CMD_FINISH: begin
                if (!finished) begin
                    for (int i = 0; i < 64; i++)
                        pad[i] = (i < fill) ? block_bytes[i] : 8'h00;
                    pad[fill] = sha1_pkg::PAD_BYTE;
                    if (fill + 1 > sha1_pkg::LEN_POS) begin
                        compress(pad);
                        for (int i = 0; i < 64; i++) pad[i] = 8'h00;
                    end
                    for (int i = 0; i < 8; i++) pad[56+i] = msg_bits[63-8*i -: 8];
                    compress(pad);
                    finished = 1'b1;
                end
                for (int i = 0; i < 5; i++)
                    digest_q.push_back('{chain[i], 3'(i), (i == 4)});
            end
            sha1_pkg::CMD_RESTART: hash_restart();
            default: ;
        endcase
    endtask

    task automatic add_row(input sha1_pkg::cmd_t cmd, input logic [7:0] data,
                           input logic has_word, input logic [31:0] word_a);
        request_row_t r;
        r.cmd = cmd; r.data = data; r.has_word = has_word; r.word_a = word_a;
        dir_rows.push_back(r);
    endtask

    // drop valid only for a nonzero gap; the caller drops it after the last request
    task automatic send(input sha1_pkg::cmd_t cmd, input logic [7:0] data);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        hash_apply(cmd, data);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send(sha1_pkg::CMD_ABSORB, 8'($urandom));
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // accept digest words with random stalls
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        digest_word_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_digest_word, m_word_index, m_last_word};
            if (digest_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected digest word %h", got);
            end else begin
                want = digest_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("digest mismatch: word %h/%h index %0d/%0d last %b/%b",
                                 want.word, got.word, want.index, got.index,
                                 want.last, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int pick;
        err_count = 0; cycle_count = 0;
        aresetn = 1'b0; s_valid = 1'b0; s_cmd = sha1_pkg::CMD_NONE; s_data_byte = '0;
        hash_restart();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message, "abc", bytes after finish, repeated finish, unused code
        add_row(sha1_pkg::CMD_FINISH,  8'h00, 1'b1, 32'hDA39A3EE);
        add_row(sha1_pkg::CMD_FINISH,  8'h00, 1'b1, 32'hDA39A3EE);
        add_row(sha1_pkg::CMD_ABSORB,  8'hFF, 1'b0, '0);
        add_row(sha1_pkg::CMD_FINISH,  8'h00, 1'b1, 32'hDA39A3EE);
        add_row(sha1_pkg::CMD_RESTART, 8'h00, 1'b0, '0);
        add_row(sha1_pkg::CMD_NONE,    8'h55, 1'b0, '0);
        add_row(sha1_pkg::CMD_ABSORB,  8'h61, 1'b0, '0);
        add_row(sha1_pkg::CMD_ABSORB,  8'h62, 1'b0, '0);
        add_row(sha1_pkg::CMD_ABSORB,  8'h63, 1'b0, '0);
        add_row(sha1_pkg::CMD_FINISH,  8'h00, 1'b1, 32'hA9993E36);
        add_row(sha1_pkg::CMD_RESTART, 8'hAA, 1'b0, '0);
        add_row(sha1_pkg::CMD_ABSORB,  8'h00, 1'b0, '0);
        add_row(sha1_pkg::CMD_ABSORB,  8'hFF, 1'b0, '0);
        add_row(sha1_pkg::CMD_FINISH,  8'h00, 1'b0, '0);
        add_row(sha1_pkg::CMD_RESTART, 8'h00, 1'b0, '0);
        foreach (dir_rows[i]) begin
            send(dir_rows[i].cmd, dir_rows[i].data);
            if (dir_rows[i].has_word && chain[0] !== dir_rows[i].word_a) begin
                err_count++;
                if (err_count <= 10)
                    $display("known digest %h, bench has %h", dir_rows[i].word_a, chain[0]);
            end
        end

        // padding edges: messages of 55, 56, 63 and 64 bytes (a 64-byte message leaves an empty tail)
        for (int i = 0; i < 4; i++) begin
            send_message(i == 0 ? 55 : i == 1 ? 56 : i == 2 ? 63 : 64);
            send(sha1_pkg::CMD_FINISH, 8'h00);
            send(sha1_pkg::CMD_RESTART, 8'h00);
        end

        // random messages; mostly short, a few crossing block edges
        for (int n = 0; n < 120; ) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                int len;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130)
                                                  : $urandom_range(0, 20);
                send_message(len);
                n += len;
                if ($urandom_range(0, 3) == 0) begin
                    send(sha1_pkg::CMD_NONE, 8'($urandom));
                    n++;
                end
                send(sha1_pkg::CMD_FINISH, 8'($urandom));
                if ($urandom_range(0, 2) == 0) begin
                    send(sha1_pkg::CMD_FINISH, 8'($urandom));
                    n++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send(sha1_pkg::CMD_ABSORB, 8'($urandom));
                    n++;
                end
                send(sha1_pkg::CMD_RESTART, 8'($urandom));
                n += 2;
            end else begin
                send(sha1_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
                n++;
            end
        end
        send(sha1_pkg::CMD_FINISH, 8'h00);
        s_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- sha1_message_digest.f -----
design/sha1_pkg.sv
design/sha1_ram.sv
design/sha1_message_digest.sv
verif/tb_top.sv
